// ===== hw/rtl/rpn_stack_evaluator_macros.svh =====
// ----------------------------------------------------------------------------
// rpn stack evaluator assertion macros
// concurrent assertion shorthands used by the checker file rpn_checker.sv
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_EVALUATOR_MACROS_SVH
`define RPN_STACK_EVALUATOR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RPN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpn assertion failed");

// next-cycle implication, disabled while reset is asserted
`define RPN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpn assertion failed");

`endif

// ===== hw/rtl/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg
// shared constants, status codes and controller/datapath interface structs
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int DATA_W          = 32;
    localparam int SYM_W           = 8;
    localparam int STATUS_W        = 3;

    // character codes
    localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F;
    localparam logic [SYM_W-1:0] CH_MOD   = 8'h25;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_BADCHAR   = 3'd1;
    localparam status_t ST_UNDERFLOW = 3'd2;
    localparam status_t ST_NOTONE    = 3'd3;
    localparam status_t ST_DIVZERO   = 3'd4;
    localparam status_t ST_OVERFLOW  = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic    capture_in;
        logic    push_digit;
        logic    set_err;
        status_t err_code;
        logic    rd_top;
        logic    rd_second;
        logic    rd_bottom;
        logic    cap_b;
        logic    cap_a;
        logic    div_start;
        logic    write_res;
        logic    load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_space;
        logic is_digit;
        logic is_op;
        logic is_divop;
        logic err_set;
        logic stack_full;
        logic few_operands;
        logic b_zero;
        logic div_done;
        logic last;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rpn_div.sv =====
// ----------------------------------------------------------------------------
// rpn_div
// radix-2 restoring signed divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rpn_pkg::DATA_W-1:0] dividend,
    input  logic [rpn_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [rpn_pkg::DATA_W-1:0] quotient,
    output logic [rpn_pkg::DATA_W-1:0] remainder
);
    import rpn_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);

    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic              q_neg_reg;
    logic              r_neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DATA_W-1:0] a_mag;
    logic [DATA_W-1:0] b_mag;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              fits;

    assign a_mag   = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
    assign b_mag   = divisor[DATA_W-1]  ? (DATA_W'(0) - divisor)  : divisor;
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = !diff[DATA_W];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start)
        begin
            rem_reg   <= '0;
            quo_reg   <= a_mag;
            dvs_reg   <= b_mag;
            q_neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            r_neg_reg <= dividend[DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = q_neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;
    assign remainder = r_neg_reg ? (DATA_W'(0) - rem_reg) : rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rpn_dp.sv =====
// ----------------------------------------------------------------------------
// rpn_dp
// datapath: operand stack memory, operand registers, alu, divider, result register
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_dp #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [rpn_pkg::SYM_W-1:0]           symbol,
    input  logic                                last,
    input  rpn_pkg::dp_cmd_t                    cmd,
    output rpn_pkg::dp_stat_t                   stat,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic signed [rpn_pkg::DATA_W-1:0]   value,
    output logic [rpn_pkg::STATUS_W-1:0]        status
);
    import rpn_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    logic [SYM_W-1:0]  symbol_reg;
    logic              last_reg;
    logic [CNT_W-1:0]  cnt_reg;
    status_t           err_reg;
    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] b_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] value_reg;
    status_t           status_reg;

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] alu_res;
    logic [DATA_W-1:0] div_q;
    logic [DATA_W-1:0] div_r;
    logic              div_done;
    logic [DATA_W-1:0] value_next;
    status_t           status_next;

    // operand stack memory
    assign rd_en = cmd.rd_top | cmd.rd_second | cmd.rd_bottom;

    always_comb begin
        rd_addr = '0;
        if (cmd.rd_top)
        begin
            rd_addr = ADDR_W'(cnt_reg - CNT_W'(1));
        end
        else if (cmd.rd_second)
        begin
            rd_addr = ADDR_W'(cnt_reg - CNT_W'(2));
        end
    end

    assign wr_en   = cmd.push_digit | cmd.write_res;
    assign wr_addr = cmd.push_digit ? cnt_reg[ADDR_W-1:0] : ADDR_W'(cnt_reg - CNT_W'(2));
    assign wr_data = cmd.push_digit ? DATA_W'(symbol_reg - CH_ZERO) : alu_res;

    always_ff @(posedge clk) begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge clk) begin
        if (cmd.capture_in)
        begin
            symbol_reg <= symbol;
            last_reg   <= last;
        end
        if (cmd.cap_b)
        begin
            b_reg <= rd_data_reg;
        end
        if (cmd.cap_a)
        begin
            a_reg <= rd_data_reg;
        end
    end

    rpn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (a_reg),
        .divisor   (b_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb begin
        case (symbol_reg)
            CH_PLUS:  alu_res = a_reg + b_reg;
            CH_MINUS: alu_res = a_reg - b_reg;
            CH_MUL:   alu_res = DATA_W'(a_reg * b_reg);
            CH_DIV:   alu_res = div_q;
            default:  alu_res = div_r;
        endcase
    end

    // stack count and error latch
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            err_reg <= ST_OK;
        end
        else if (cmd.load_out)
        begin
            cnt_reg <= '0;
            err_reg <= ST_OK;
        end
        else
        begin
            if (cmd.push_digit)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (cmd.write_res)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (cmd.set_err)
            begin
                err_reg <= cmd.err_code;
            end
        end
    end

    // result register
    always_comb begin
        if (err_reg != ST_OK)
        begin
            value_next  = '0;
            status_next = err_reg;
        end
        else if (cnt_reg != CNT_W'(1))
        begin
            value_next  = '0;
            status_next = ST_NOTONE;
        end
        else
        begin
            value_next  = rd_data_reg;
            status_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load_out)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    // status toward the controller
    always_comb begin
        stat.is_space     = (symbol_reg == CH_SPACE);
        stat.is_digit     = (symbol_reg >= CH_ZERO) && (symbol_reg <= CH_NINE);
        stat.is_divop     = (symbol_reg == CH_DIV) || (symbol_reg == CH_MOD);
        stat.is_op        = stat.is_divop || (symbol_reg == CH_PLUS)
                            || (symbol_reg == CH_MINUS) || (symbol_reg == CH_MUL);
        stat.err_set      = (err_reg != ST_OK);
        stat.stack_full   = (cnt_reg == CNT_W'(STACK_DEPTH));
        stat.few_operands = (cnt_reg < CNT_W'(2));
        stat.b_zero       = (b_reg == '0);
        stat.div_done     = div_done;
        stat.last         = last_reg;
        stat.out_busy     = out_valid_reg && out_stall;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rpn_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpn_ctrl
// controller state machine sequencing one character through the datapath
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rpn_pkg::dp_stat_t stat,
    output rpn_pkg::dp_cmd_t  cmd
);
    import rpn_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECODE   = 8'b0000_0010,
        S_RD_B     = 8'b0000_0100,
        S_RD_A     = 8'b0000_1000,
        S_EXEC     = 8'b0001_0000,
        S_DIV      = 8'b0010_0000,
        S_READ_FIN = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t after_item;

    // where to go once the character is handled
    assign after_item = stat.last ? S_READ_FIN : S_IDLE;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.err_code = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture_in = 1'b1;
                    state_next     = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = after_item;
                if (stat.err_set || stat.is_space)
                begin
                    state_next = after_item;
                end
                else if (stat.is_digit)
                begin
                    if (stat.stack_full)
                    begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_OVERFLOW;
                    end
                    else
                    begin
                        cmd.push_digit = 1'b1;
                    end
                end
                else if (stat.is_op)
                begin
                    if (stat.few_operands)
                    begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_UNDERFLOW;
                    end
                    else
                    begin
                        cmd.rd_top = 1'b1;
                        state_next = S_RD_B;
                    end
                end
                else
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = ST_BADCHAR;
                end
            end
            S_RD_B:
            begin
                cmd.cap_b     = 1'b1;
                cmd.rd_second = 1'b1;
                state_next    = S_RD_A;
            end
            S_RD_A:
            begin
                cmd.cap_a  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (!stat.is_divop)
                begin
                    cmd.write_res = 1'b1;
                    state_next    = after_item;
                end
                else if (stat.b_zero)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = ST_DIVZERO;
                    state_next   = after_item;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.write_res = 1'b1;
                    state_next    = after_item;
                end
            end
            S_READ_FIN:
            begin
                cmd.rd_bottom = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/rpn_stack_evaluator.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// reverse-polish expression evaluator, one ascii character per input transfer
// ----------------------------------------------------------------------------
// usage
//   input channel: symbol and last, one character per transfer (in_valid high,
//   in_stall low); last marks the final character of an expression
//   output channel: value and status, one transfer per expression, issued
//   after the final character; value is 0 whenever status is not ok
//   timing: one character at a time; a space, digit, ignored character, bad
//   character, underflow or overflow goes through capture and decode before
//   the next possible transfer, + - * and a zero divisor also take the operand
//   fetches and execute, and / % add a wait for the radix-2 divider that retires
//   one quotient bit a cycle; the final character adds the bottom-of-stack read
//   and the result load; the operand stack is a memory with registered read, so
//   every operand fetch takes a controller state of its own
//   reset: stack count, error latch, controller and output valid clear; the
//   stack memory is not cleared and needs no clearing pass
//   receiver stall: the result register holds; the block keeps taking input
//   characters and only waits when a second result is ready to load
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // character input
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rpn_pkg::SYM_W-1:0]         symbol,
    input  logic                              last,
    // result output
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [rpn_pkg::DATA_W-1:0] value,
    output logic [rpn_pkg::STATUS_W-1:0]      status
);
    import rpn_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencing: decode, operand fetch, execute, divider wait, result load
    rpn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // stack memory, alu, divider and the result register
    rpn_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .symbol    (symbol),
        .last      (last),
        .cmd       (cmd),
        .stat      (stat),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .value     (value),
        .status    (status)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/rpn_checker.sv =====
// ----------------------------------------------------------------------------
// rpn_checker
// port-level assertions for the rpn stack evaluator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "rpn_stack_evaluator_macros.svh"

module rpn_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [rpn_pkg::DATA_W-1:0] value,
    input logic [rpn_pkg::STATUS_W-1:0]      status
);
    import rpn_pkg::*;

    // a stalled result holds
    `RPN_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(value) && $stable(status))

    // an error result carries a zero value
    `RPN_ASSERT_IMP(a_err_value_zero, clk, rst_n, out_valid && (status != ST_OK), value == '0)

    // one character at a time: busy right after an input transfer
    `RPN_ASSERT_NXT(a_busy_after_transfer, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (.*);

`default_nettype wire
